[hdl/ash_pkg.sv]
// ----------------------------------------------------------------------------
// ash_pkg
// Shared types, constants and helpers for the autoranged signal history.
// ----------------------------------------------------------------------------
package ash_pkg;

    localparam int ASH_COLUMNS = 128;

    localparam logic [7:0] HEIGHT_RESET = 8'd64;
    localparam logic [7:0] LEVEL_MAX    = 8'hff;
    localparam logic [7:0] MIN_RESET    = 8'hff;
    localparam logic [7:0] MAX_RESET    = 8'h00;

    localparam logic [9:0] EXT900_FIRST  = 10'd975;
    localparam logic [9:0] DCS1800_FIRST = 10'd512;

    localparam logic [1:0] BAND_900    = 2'd0;
    localparam logic [1:0] BAND_EXT900 = 2'd1;
    localparam logic [1:0] BAND_1800   = 2'd2;

    localparam logic       CMD_RECORD = 1'b0;
    localparam logic       CMD_READ   = 1'b1;

    localparam int         DIV_STEPS  = 8;

    typedef struct packed {
        logic       command;
        logic [7:0] power;
        logic [9:0] channel;
        logic [6:0] read_column;
    } t_in_item;

    typedef struct packed {
        logic [7:0] level;
        logic [1:0] band;
        logic [6:0] column;
    } t_out_item;

    typedef struct packed {
        logic [7:0] level;
        logic [1:0] band;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BOUNDS,
        ST_MULT,
        ST_DIV,
        ST_WRITE,
        ST_READ,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic bounds;
        logic mult;
        logic div_step;
        logic mem_wr;
        logic mem_rd;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [1:0] band_of(input logic [9:0] ch);
        logic [1:0] b;
        if (ch >= EXT900_FIRST) begin
            b = BAND_EXT900;
        end else if (ch >= DCS1800_FIRST) begin
            b = BAND_1800;
        end else begin
            b = BAND_900;
        end
        return b;
    endfunction

endpackage

[hdl/ash_ctrl.sv]
// ----------------------------------------------------------------------------
// ash_ctrl
// Sequencer for the signal history: clearing pass, record and read flows.
// ----------------------------------------------------------------------------
module ash_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_cmd_read,
    input  ash_pkg::t_dp_status   i_status,
    output ash_pkg::t_ctrl_cmd    o_cmd,
    output logic                  o_in_stall
);

    ash_pkg::t_state r_state;
    ash_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ash_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ash_pkg::ST_CLEAR: begin
                if (i_status.clr_done) begin
                    n_state = ash_pkg::ST_IDLE;
                end
            end
            ash_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_cmd_read == ash_pkg::CMD_READ) ?
                              ash_pkg::ST_READ : ash_pkg::ST_BOUNDS;
                end
            end
            ash_pkg::ST_BOUNDS: n_state = ash_pkg::ST_MULT;
            ash_pkg::ST_MULT:   n_state = ash_pkg::ST_DIV;
            ash_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ash_pkg::ST_WRITE;
                end
            end
            ash_pkg::ST_WRITE:  n_state = ash_pkg::ST_FINISH;
            ash_pkg::ST_READ:   n_state = ash_pkg::ST_FINISH;
            ash_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ash_pkg::ST_IDLE;
                end
            end
            default: n_state = ash_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ash_pkg::ST_CLEAR:  o_cmd.clear_wr = 1'b1;
            ash_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ash_pkg::ST_BOUNDS: o_cmd.bounds   = 1'b1;
            ash_pkg::ST_MULT:   o_cmd.mult     = 1'b1;
            ash_pkg::ST_DIV:    o_cmd.div_step = 1'b1;
            ash_pkg::ST_WRITE:  o_cmd.mem_wr   = 1'b1;
            ash_pkg::ST_READ:   o_cmd.mem_rd   = 1'b1;
            ash_pkg::ST_FINISH: o_cmd.load_out = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

[hdl/ash_dp.sv]
// ----------------------------------------------------------------------------
// ash_dp
// Datapath: range tracking, scaling multiply, bit-serial divider, column
// memory and output register.
// ----------------------------------------------------------------------------
module ash_dp #(
    parameter int COLUMNS = ash_pkg::ASH_COLUMNS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data,
    input  ash_pkg::t_in_item     i_in_data,
    input  logic                  i_out_stall,
    input  ash_pkg::t_ctrl_cmd    i_cmd,
    output ash_pkg::t_dp_status   o_status,
    output logic                  o_out_valid,
    output ash_pkg::t_out_item    o_out_data
);

    localparam int AW   = $clog2(COLUMNS);
    localparam int CMPW = (AW > 7) ? AW + 1 : 8;
    localparam int CW   = $clog2(ash_pkg::DIV_STEPS);

    logic [7:0]           r_height;
    ash_pkg::t_in_item    r_item;
    logic [6:0]           r_col;
    logic [7:0]           r_min;
    logic [7:0]           r_max;
    logic [7:0]           r_span;
    logic [AW-1:0]        r_wcol;
    logic [AW-1:0]        r_clr;
    logic                 r_zero;
    logic                 r_sat;
    logic [7:0]           r_rem;
    logic [7:0]           r_lo;
    logic [CW-1:0]        r_cnt;
    logic                 r_rd_ok;
    ash_pkg::t_entry      r_rdata;
    logic                 r_out_valid;
    ash_pkg::t_out_item   r_out;
    ash_pkg::t_entry      r_mem [COLUMNS];

    logic [7:0]           n_min;
    logic [7:0]           n_max;
    logic [7:0]           n_span;
    logic [AW-1:0]        n_wcol;
    logic [7:0]           n_rem;
    logic [15:0]          w_prod;
    logic [8:0]           w_trial;
    logic [8:0]           w_diff;
    logic                 w_ge;
    logic [7:0]           w_level;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    ash_pkg::t_entry      w_wdata;
    logic [AW-1:0]        w_raddr;
    logic                 w_out_free;
    ash_pkg::t_out_item   w_result;

    always_comb begin
        n_min  = r_min;
        n_max  = r_max;
        n_span = r_span;
        if (r_item.power != 8'd0) begin
            if (r_item.power > r_max) begin
                n_max = r_item.power;
            end
            if (r_item.power < r_min) begin
                n_min = r_item.power;
            end
            if ((r_item.power > r_max) || (r_item.power < r_min)) begin
                n_span = n_max - n_min;
            end
        end
    end

    assign w_prod  = 16'(r_height) * 16'(r_max - r_item.power);
    assign w_trial = {r_rem, r_lo[7]};
    assign w_ge    = w_trial >= {1'b0, r_span};
    assign w_diff  = w_trial - {1'b0, r_span};
    assign n_rem   = w_ge ? w_diff[7:0] : w_trial[7:0];

    assign w_level = r_zero ? 8'd0 : (r_sat ? ash_pkg::LEVEL_MAX : r_lo);

    assign n_wcol  = (r_wcol == AW'(COLUMNS - 1)) ? '0 : r_wcol + AW'(1);

    assign w_we    = i_cmd.clear_wr | i_cmd.mem_wr;
    assign w_waddr = i_cmd.clear_wr ? r_clr : r_wcol;
    assign w_wdata = i_cmd.clear_wr ? '0 :
                     {w_level, ash_pkg::band_of(r_item.channel)};
    assign w_raddr = AW'(r_item.read_column);

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_item.command == ash_pkg::CMD_READ) begin
            w_result.level = r_rd_ok ? r_rdata.level : 8'd0;
            w_result.band  = r_rd_ok ? r_rdata.band : ash_pkg::BAND_900;
        end else begin
            w_result.level = w_level;
            w_result.band  = ash_pkg::band_of(r_item.channel);
        end
        w_result.column = r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height    <= ash_pkg::HEIGHT_RESET;
            r_min       <= ash_pkg::MIN_RESET;
            r_max       <= ash_pkg::MAX_RESET;
            r_span      <= 8'd0;
            r_wcol      <= '0;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_height <= i_cfg_wr_data;
            end
            if (i_cmd.clear_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.bounds) begin
                r_min  <= n_min;
                r_max  <= n_max;
                r_span <= n_span;
            end
            if (i_cmd.mult) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.mem_wr) begin
                r_wcol <= n_wcol;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_data;
            r_col  <= (i_in_data.command == ash_pkg::CMD_READ) ?
                      i_in_data.read_column : 7'(r_wcol);
        end
        if (i_cmd.mult) begin
            r_zero <= (r_item.power == 8'd0) || (r_span == 8'd0);
            r_sat  <= w_prod[15:8] >= r_span;
            r_rem  <= w_prod[15:8];
            r_lo   <= w_prod[7:0];
        end else if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_lo   <= {r_lo[6:0], w_ge};
        end
        if (i_cmd.load_out) begin
            r_out <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[w_raddr];
            r_rd_ok <= CMPW'(r_item.read_column) < CMPW'(COLUMNS);
        end
    end

    assign o_status.clr_done = r_clr == AW'(COLUMNS - 1);
    assign o_status.div_done = r_cnt == CW'(ash_pkg::DIV_STEPS - 1);
    assign o_status.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hdl/autoranged_signal_history.sv]
// ----------------------------------------------------------------------------
// autoranged_signal_history
// Ring of scaled signal levels and channel bands for a scrolling graph.
// ----------------------------------------------------------------------------
// After reset the block clears every column of its memory and accepts no
// item until that pass is done. A record item goes from acceptance to a
// loaded result through these steps in order: widen the running range, do
// the height multiply, run the bit-serial divider that yields one quotient
// bit per cycle, write the column and load the output register. A read item
// goes through a registered read of the column memory and then loads the
// output register. One item is in work at a time; a finished result waits
// in the output register while the next item is taken, and a held result
// stalls the block only when the following one is done.
module autoranged_signal_history #(
    parameter int COLUMNS = ash_pkg::ASH_COLUMNS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ash_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ash_pkg::t_out_item    o_out_data
);

    ash_pkg::t_ctrl_cmd  w_cmd;
    ash_pkg::t_dp_status w_status;

    ash_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd_read (i_in_data.command),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    ash_dp #(
        .COLUMNS (COLUMNS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_out_stall   (i_out_stall),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule

[verif/tb_autoranged_signal_history.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_autoranged_signal_history
// Self-checking testbench for the autoranged signal history. A built-in
// predictor tracks the running power range, the write column and the column
// stores, and every result item is compared field by field against it.
// Directed items cover the range corners and channel band edges, then random
// phases run under different graph heights and sender and receiver idling,
// including a long output hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_autoranged_signal_history;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS    = 136;

    logic      i_clk         = 1'b0;
    logic      i_rst_n       = 1'b0;
    logic      i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'd0;
    logic      i_in_valid    = 1'b0;
    logic      o_in_stall;
    ash_pkg::t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall   = 1'b0;
    ash_pkg::t_out_item o_out_data;

    autoranged_signal_history u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    logic [7:0] disp_height = ash_pkg::HEIGHT_RESET;
    logic [7:0] hist_min    = ash_pkg::MIN_RESET;
    logic [7:0] hist_max    = ash_pkg::MAX_RESET;
    logic [7:0] hist_span   = 8'd0;
    logic [6:0] hist_wcol   = 7'd0;
    logic [7:0] lvl_mem  [ash_pkg::ASH_COLUMNS];
    logic [1:0] band_mem [ash_pkg::ASH_COLUMNS];

    ash_pkg::t_in_item  pending_items[$];
    ash_pkg::t_out_item expected_columns[$];
    ash_pkg::t_out_item col_want;

    int sender_idle_pct = 0;
    int rx_stall_pct    = 0;
    bit hold_req        = 1'b0;
    bit hold_taken      = 1'b0;
    int hold_left       = 0;

    int cycle_count     = 0;
    int fail_count      = 0;
    int records_seen    = 0;
    int reads_seen      = 0;
    int results_checked = 0;

    function automatic ash_pkg::t_out_item predict_graph_column(input ash_pkg::t_in_item it);
        ash_pkg::t_out_item res;
        int unsigned quot;
        logic [6:0]  col;
        bit          moved;
        moved = 1'b0;
        if (it.command == ash_pkg::CMD_RECORD) begin
            col = hist_wcol;
            if (it.power != 8'd0) begin
                if (it.power > hist_max) begin
                    hist_max = it.power;
                    moved = 1'b1;
                end
                if (it.power < hist_min) begin
                    hist_min = it.power;
                    moved = 1'b1;
                end
                if (moved) begin
                    hist_span = hist_max - hist_min;
                end
            end
            if (it.power == 8'd0 || hist_span == 8'd0) begin
                quot = 0;
            end else begin
                quot = (int'(disp_height) * int'(hist_max - it.power)) / int'(hist_span);
                if (quot > int'(ash_pkg::LEVEL_MAX)) begin
                    quot = 32'(ash_pkg::LEVEL_MAX);
                end
            end
            res.level = quot[7:0];
            if (it.channel >= ash_pkg::EXT900_FIRST) begin
                res.band = ash_pkg::BAND_EXT900;
            end else if (it.channel >= ash_pkg::DCS1800_FIRST) begin
                res.band = ash_pkg::BAND_1800;
            end else begin
                res.band = ash_pkg::BAND_900;
            end
            lvl_mem[col]  = res.level;
            band_mem[col] = res.band;
            hist_wcol = (int'(col) + 1 >= ash_pkg::ASH_COLUMNS) ? 7'd0 : col + 7'd1;
        end else begin
            col = it.read_column;
            res.level = lvl_mem[col];
            res.band  = band_mem[col];
        end
        res.column = col;
        return res;
    endfunction

    function automatic ash_pkg::t_in_item random_item();
        ash_pkg::t_in_item it;
        it.command = ($urandom_range(99) < 70) ? ash_pkg::CMD_RECORD : ash_pkg::CMD_READ;
        case ($urandom_range(9))
            0: it.power = 8'd0;
            1: it.power = 8'd255;
            2: it.power = 8'd1;
            default: it.power = 8'($urandom_range(255));
        endcase
        case ($urandom_range(11))
            0: it.channel = 10'd0;
            1: it.channel = ash_pkg::DCS1800_FIRST - 10'd1;
            2: it.channel = ash_pkg::DCS1800_FIRST;
            3: it.channel = ash_pkg::EXT900_FIRST - 10'd1;
            4: it.channel = ash_pkg::EXT900_FIRST;
            5: it.channel = 10'd1023;
            default: it.channel = 10'($urandom_range(1023));
        endcase
        it.read_column = 7'($urandom_range(ash_pkg::ASH_COLUMNS - 1));
        return it;
    endfunction

    task automatic push_item(input logic cmd, input int pwr, input int ch, input int rc);
        ash_pkg::t_in_item it;
        it.command     = cmd;
        it.power       = pwr[7:0];
        it.channel     = ch[9:0];
        it.read_column = rc[6:0];
        pending_items.push_back(it);
    endtask

    task automatic compare_field(input string fname, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", fname, want, got);
            fail_count++;
        end
    endtask

    task automatic write_height(input logic [7:0] h);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= h;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        disp_height = h;
    endtask

    task automatic set_idling(input int s_pct, input int r_pct);
        @(negedge i_clk);
        sender_idle_pct = s_pct;
        rx_stall_pct    = r_pct;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_columns.size() != 0 || i_in_valid) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int s_pct, input int r_pct);
        set_idling(s_pct, r_pct);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            pending_items.push_back(random_item());
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_in_data  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (i_in_data.command == ash_pkg::CMD_RECORD) begin
                records_seen++;
            end else begin
                reads_seen++;
            end
            expected_columns.push_back(predict_graph_column(i_in_data));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            i_out_stall <= 1'b1;
            hold_left   <= RX_HOLD_CYCLES;
            hold_taken  <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_columns.size() == 0) begin
                $error("unexpected result item: level %0d band %0d column %0d",
                       o_out_data.level, o_out_data.band, o_out_data.column);
                fail_count++;
            end else begin
                col_want = expected_columns.pop_front();
                compare_field("level", int'(col_want.level), int'(o_out_data.level));
                compare_field("band", int'(col_want.band), int'(o_out_data.band));
                compare_field("column", int'(col_want.column), int'(o_out_data.column));
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, expected_columns.size());
            $display("autoranged_signal_history: mismatch");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < ash_pkg::ASH_COLUMNS; c++) begin
            lvl_mem[c]  = 8'd0;
            band_mem[c] = ash_pkg::BAND_900;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first sample leaves a zero span, then the range opens up.
        set_idling(0, 0);
        push_item(ash_pkg::CMD_RECORD, 200, 0, 0);
        push_item(ash_pkg::CMD_RECORD, 100, 511, 127);
        push_item(ash_pkg::CMD_RECORD, 0, 512, 0);
        push_item(ash_pkg::CMD_RECORD, 150, 974, 0);
        push_item(ash_pkg::CMD_RECORD, 255, 975, 0);
        push_item(ash_pkg::CMD_RECORD, 1, 1023, 0);
        push_item(ash_pkg::CMD_RECORD, 128, 700, 0);
        for (int c = 0; c < 7; c++) begin
            push_item(ash_pkg::CMD_READ, 255, 1023, c);
        end
        push_item(ash_pkg::CMD_READ, 0, 0, 127);
        push_item(ash_pkg::CMD_READ, 0, 0, 64);
        wait_drained();

        write_height(8'd0);
        push_item(ash_pkg::CMD_RECORD, 50, 300, 0);
        push_item(ash_pkg::CMD_RECORD, 0, 980, 0);
        push_item(ash_pkg::CMD_READ, 0, 0, 7);
        wait_drained();

        write_height(8'd255);
        push_item(ash_pkg::CMD_RECORD, 1, 600, 0);
        push_item(ash_pkg::CMD_RECORD, 255, 100, 0);
        push_item(ash_pkg::CMD_RECORD, 128, 1000, 0);
        push_item(ash_pkg::CMD_READ, 0, 0, 9);
        wait_drained();

        run_random_phase(0, 0);
        write_height(8'd1);
        run_random_phase(81, 0);
        write_height(8'($urandom_range(2, 254)));
        run_random_phase(0, 81);
        write_height(8'($urandom_range(255)));
        run_random_phase(28, 28);

        write_height(ash_pkg::HEIGHT_RESET);
        @(negedge i_clk);
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        hold_req        = 1'b1;
        for (int n = 0; n < 40; n++) begin
            pending_items.push_back(random_item());
        end
        wait_drained();
        hold_req = 1'b0;
        run_random_phase(0, 0);

        $display("Run covered %0d record and %0d read items, %0d results checked,",
                 records_seen, reads_seen, results_checked);
        $display("heights 0, 1, 64, 255 and random, with idle, stall and backlog phases.");
        if (fail_count == 0) begin
            $display("autoranged_signal_history: match");
        end else begin
            $display("autoranged_signal_history: mismatch");
        end
        $finish;
    end

endmodule
